// ===== rtl/edc_pkg.sv =====
// Shared constants, types and helpers for the 1-D collision step block.
`default_nettype none
package edc_pkg;
    localparam int MAX_PARTICLES_DEF = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME = 1'b1;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    // Request and result bundle of the shared divider.
    typedef struct packed {
        logic        start;
        logic [79:0] num;
        logic [79:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [79:0] quo;
    } div_rsp_t;

    // Saturate a wide signed value into 32 bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [81:0] v);
        logic signed [81:0] hi;
        logic signed [81:0] lo;
        hi = 82'sd2147483647;
        lo = -82'sd2147483648;
        if (v > hi) sat32 = 32'sh7FFF_FFFF;
        else if (v < lo) sat32 = 32'sh8000_0000;
        else sat32 = v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/event_driven_1d_collision_step.sv =====
// Top level of the 1-D event-driven hard-rod collision step.
// A load transaction writes one row entry. A step shares one divider: the scan divides once
// per approaching pair, the collision at most once, and the energy once per massive entry;
// then one result transaction per entry follows; input waits until the last result is taken.
// Reset clears the control state and the elapsed clock; the row is undefined until loaded.
`default_nettype none
module event_driven_1d_collision_step #(
    parameter int MAX_PARTICLES = edc_pkg::MAX_PARTICLES_DEF,
    parameter int FRACTION_BITS = edc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             func,
    input  wire logic [$clog2(MAX_PARTICLES)-1:0] particle_index,
    input  wire logic signed [31:0]               init_position,
    input  wire logic signed [31:0]               init_velocity,
    input  wire logic [16:0]                      inverse_mass,
    input  wire logic [15:0]                      radius,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [$clog2(MAX_PARTICLES)-1:0]      out_index,
    output logic signed [31:0]                    out_position,
    output logic signed [31:0]                    step_time,
    output logic [$clog2(MAX_PARTICLES)-1:0]      pair_index,
    output logic [47:0]                           elapsed_time,
    output logic [47:0]                           kinetic_energy,
    output logic                                  no_collision,
    output logic                                  finished,
    output logic                                  last,
    input  wire logic                             cfg_we,
    input  wire logic [edc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [edc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int IW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam logic [47:0] MASK48_V = edc_pkg::MASK48;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SDIV  = 4'd3;
    localparam logic [3:0] S_ADV   = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CDIV  = 4'd6;
    localparam logic [3:0] S_ERD   = 4'd7;
    localparam logic [3:0] S_EDIV  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_SRD2  = 4'd10;
    localparam logic [3:0] S_CRD2  = 4'd11;

    logic signed [31:0] pos_mem [MAX_PARTICLES];
    logic signed [31:0] vel_mem [MAX_PARTICLES];
    logic [16:0]        im_mem  [MAX_PARTICLES];
    logic [15:0]        rad_mem [MAX_PARTICLES];

    logic [3:0]  state_reg, state_next;
    logic [6:0]  count_reg;
    logic [47:0] stop_reg;
    logic [47:0] clock_reg, clock_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] pair_reg, pair_next;
    logic          found_reg, found_next;
    logic signed [31:0] dt_reg, dt_next;
    logic [47:0] energy_reg, energy_next;
    logic        fin_reg, fin_next;

    // Registered operands read from the row.
    logic signed [31:0] pa_reg, pb_reg, va_reg, vb_reg;
    logic [16:0]        ia_reg, ib_reg;
    logic [15:0]        ra_reg, rb_reg;
    logic               neg_reg, neg_next;
    logic               ld_a_reg, ld_a_next;

    edc_pkg::div_req_t dreq;
    edc_pkg::div_rsp_t drsp;

    edc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [CW-1:0] n_sat;
    always_comb
    begin
        if ({1'b0, count_reg} > 8'(MAX_PARTICLES)) n_sat = CW'(MAX_PARTICLES);
        else if (count_reg < 7'd3) n_sat = CW'(3);
        else n_sat = CW'(count_reg);
    end

    // Row read address: idx, and idx+1 for neighbour accesses.
    logic [IW-1:0] idx_p1;
    assign idx_p1 = idx_reg + IW'(1);

    // Combinational arithmetic on registered operands.
    logic signed [32:0] rel;
    logic signed [33:0] gap;
    logic signed [81:0] tcand;
    logic signed [64:0] prod;
    logic signed [81:0] newpos;
    logic signed [81:0] clk_sum;
    logic [17:0]        imsum;
    logic signed [50:0] mom;
    logic signed [81:0] com_s;
    logic signed [81:0] nvl, nvr;
    logic [31:0]        vmag;
    logic [63:0]        vsq;
    logic signed [81:0] gap_sh;
    logic [47:0]        term;
    logic [48:0]        esum;

    always_comb
    begin
        rel     = 33'(va_reg) - 33'(vb_reg);
        gap     = (34'(pb_reg) - 34'($signed({1'b0, rb_reg})))
                - (34'(pa_reg) + 34'($signed({1'b0, ra_reg})));
        gap_sh  = 82'(gap) <<< FRACTION_BITS;
        tcand   = neg_reg ? -$signed({2'b00, drsp.quo}) : $signed({2'b00, drsp.quo});
        prod    = 65'(dt_reg) * 65'(va_reg);
        newpos  = 82'(pa_reg) + 82'(prod >>> FRACTION_BITS);
        clk_sum = $signed({34'd0, clock_reg}) + 82'(dt_reg);
        imsum   = 18'(ia_reg) + 18'(ib_reg);
        mom     = 51'($signed({1'b0, ia_reg})) * 51'(vb_reg)
                + 51'(va_reg) * 51'($signed({1'b0, ib_reg}));
        com_s   = tcand;
        nvl     = (com_s <<< 1) - 82'(va_reg);
        nvr     = (com_s <<< 1) - 82'(vb_reg);
        vmag    = va_reg[31] ? 32'(-33'(va_reg)) : va_reg;
        vsq     = 64'(vmag) * 64'(vmag);
        term    = (drsp.quo > 80'(MASK48_V)) ? MASK48_V : drsp.quo[47:0];
        esum    = 49'(energy_reg) + 49'(term);
    end

    logic signed [31:0] tsat;
    assign tsat = edc_pkg::sat32(tcand);

    // Sequencer.
    logic wr_pos, wr_vl, wr_vr;
    logic signed [31:0] wr_pos_d, wr_vl_d, wr_vr_d;

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        pair_next   = pair_reg;
        found_next  = found_reg;
        dt_next     = dt_reg;
        energy_next = energy_reg;
        fin_next    = fin_reg;
        clock_next  = clock_reg;
        neg_next    = neg_reg;
        ld_a_next   = 1'b0;
        dreq        = '0;
        wr_pos      = 1'b0;
        wr_vl       = 1'b0;
        wr_vr       = 1'b0;
        wr_pos_d    = edc_pkg::sat32(newpos);
        wr_vl_d     = edc_pkg::sat32(nvl);
        wr_vr_d     = edc_pkg::sat32(nvr);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && func == edc_pkg::FUNC_STEP)
                begin
                    n_next     = n_sat;
                    idx_next   = '0;
                    found_next = 1'b0;
                    dt_next    = '0;
                    pair_next  = '0;
                    state_next = S_SRD;
                end
            end
            S_SRD:
                state_next = S_SRD2;
            S_SRD2:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (rel > 33'sd0)
                begin
                    neg_next   = gap_sh[81] ^ rel[32];
                    dreq.start = 1'b1;
                    dreq.num   = gap_sh[81] ? 80'(-gap_sh) : 80'(gap_sh);
                    dreq.den   = 80'(rel);
                    state_next = S_SDIV;
                end
                else if (CW'(idx_reg) + CW'(2) >= n_reg)
                begin
                    idx_next   = '0;
                    state_next = found_reg ? S_ADV : S_ERD;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_SRD;
                end
            end
            S_SDIV:
            begin
                if (drsp.done)
                begin
                    if (!found_reg || tsat < dt_reg)
                    begin
                        dt_next   = tsat;
                        pair_next = idx_reg;
                    end
                    found_next = 1'b1;
                    if (CW'(idx_reg) + CW'(2) >= n_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_ADV;
                    end
                    else
                    begin
                        idx_next   = idx_p1;
                        state_next = S_SRD;
                    end
                end
            end
            S_ADV:
            begin
                // Operands of idx are registered, so they arrive in the next cycle; ld_a marks them valid.
                ld_a_next = 1'b1;
                if (ld_a_reg)
                begin
                    ld_a_next = 1'b0;
                    wr_pos    = 1'b1;
                    if (CW'(idx_reg) + CW'(1) >= n_reg)
                    begin
                        idx_next   = pair_reg;
                        if (clk_sum < 82'sd0) clock_next = '0;
                        else if (clk_sum > 82'(MASK48_V)) clock_next = MASK48_V;
                        else clock_next = clk_sum[47:0];
                        state_next = S_CRD;
                    end
                    else
                        idx_next = idx_p1;
                end
            end
            S_CRD:
                state_next = S_CRD2;
            S_CRD2:
            begin
                if (imsum != 18'd0)
                begin
                    neg_next   = mom[50];
                    dreq.start = 1'b1;
                    dreq.num   = mom[50] ? 80'(-mom) : 80'(mom);
                    dreq.den   = 80'(imsum);
                    state_next = S_CDIV;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
            end
            S_CDIV:
            begin
                if (drsp.done)
                begin
                    wr_vl      = 1'b1;
                    wr_vr      = 1'b1;
                    idx_next   = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                ld_a_next = 1'b1;
                if (ld_a_reg)
                begin
                    ld_a_next = 1'b0;
                    if (ia_reg != 17'd0)
                    begin
                        dreq.start = 1'b1;
                        dreq.num   = 80'(vsq);
                        dreq.den   = 80'({ia_reg, 1'b0});
                        state_next = S_EDIV;
                    end
                    else if (CW'(idx_reg) + CW'(1) >= n_reg)
                    begin
                        idx_next   = '0;
                        fin_next   = clock_reg > stop_reg;
                        state_next = S_OUT;
                    end
                    else
                        idx_next = idx_p1;
                end
            end
            S_EDIV:
            begin
                if (drsp.done)
                begin
                    energy_next = esum[48] ? MASK48_V : esum[47:0];
                    if (CW'(idx_reg) + CW'(1) >= n_reg)
                    begin
                        idx_next   = '0;
                        fin_next   = clock_reg > stop_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_p1;
                        state_next = S_ERD;
                    end
                end
            end
            S_OUT:
            begin
                ld_a_next = 1'b1;
                if (ld_a_reg && out_ready)
                begin
                    ld_a_next = 1'b0;
                    if (CW'(idx_reg) + CW'(1) >= n_reg)
                    begin
                        energy_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                        idx_next = idx_p1;
                end
                else if (ld_a_reg)
                    ld_a_next = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= 7'd52;
            stop_reg   <= 48'd6553600;
            clock_reg  <= '0;
            n_reg      <= CW'(3);
            idx_reg    <= '0;
            pair_reg   <= '0;
            found_reg  <= 1'b0;
            dt_reg     <= '0;
            energy_reg <= '0;
            fin_reg    <= 1'b0;
            neg_reg    <= 1'b0;
            ld_a_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clock_reg  <= clock_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            pair_reg   <= pair_next;
            found_reg  <= found_next;
            dt_reg     <= dt_next;
            energy_reg <= energy_next;
            fin_reg    <= fin_next;
            neg_reg    <= neg_next;
            ld_a_reg   <= ld_a_next;
            if (cfg_we && cfg_index == edc_pkg::REG_PARTICLE_COUNT)
                count_reg <= cfg_data[6:0];
            if (cfg_we && cfg_index == edc_pkg::REG_STOP_TIME)
                stop_reg <= cfg_data[47:0];
        end
    end

    // Row memories: loads, position advance and collision write-back.
    logic load_go;
    assign load_go = in_valid && in_ready && func == edc_pkg::FUNC_LOAD;

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            pos_mem[particle_index] <= init_position;
            vel_mem[particle_index] <= (inverse_mass != 17'd0) ? init_velocity : 32'sd0;
            im_mem[particle_index]  <= inverse_mass;
            rad_mem[particle_index] <= radius;
        end
        else if (wr_pos)
            pos_mem[idx_reg] <= wr_pos_d;
        else if (wr_vl)
            vel_mem[idx_reg] <= wr_vl_d;
        if (wr_vr)
            vel_mem[idx_p1] <= wr_vr_d;
        pa_reg <= pos_mem[idx_reg];
        va_reg <= vel_mem[idx_reg];
        ia_reg <= im_mem[idx_reg];
        ra_reg <= rad_mem[idx_reg];
        pb_reg <= pos_mem[idx_p1];
        vb_reg <= vel_mem[idx_p1];
        ib_reg <= im_mem[idx_p1];
        rb_reg <= rad_mem[idx_p1];
    end

    // Result transaction fields.
    assign out_valid      = (state_reg == S_OUT) && ld_a_reg;
    assign out_index      = idx_reg;
    assign out_position   = pa_reg;
    assign step_time      = dt_reg;
    assign pair_index     = pair_reg;
    assign elapsed_time   = clock_reg;
    assign kinetic_energy = energy_reg;
    assign no_collision   = !found_reg;
    assign finished       = fin_reg;
    assign last           = (CW'(idx_reg) + CW'(1) >= n_reg);
endmodule
`default_nettype wire

// ===== rtl/edc_div.sv =====
// Shared restoring divider for unsigned magnitudes, one quotient bit a cycle.
`default_nettype none
module edc_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire edc_pkg::div_req_t req,
    output edc_pkg::div_rsp_t  rsp
);
    logic [79:0] quo_reg, quo_next;
    logic [80:0] rem_reg, rem_next;
    logic [79:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [80:0] trial;

    // One shift and subtract step per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[79:0], quo_reg[79]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd80;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[78:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[78:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/edc_checker.sv =====
// Port-level checker for the collision step block and its bind.
`default_nettype none
module edc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic last,
    input wire logic no_collision,
    input wire logic signed [31:0] step_time
);
    // No new transaction is taken while results are pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while results pending");

    // A stalled result holds its last flag.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(last))
        else $error("result dropped under stall");

    // A no-collision step reports zero step time.
    a_nc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_collision |-> step_time == 32'sd0)
        else $error("step time nonzero without collision");

    // After the final result the block is ready again.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready)
        else $error("not ready after final result");
endmodule

bind event_driven_1d_collision_step edc_checker u_edc_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .last(last),
    .no_collision(no_collision), .step_time(step_time)
);
`default_nettype wire
